@@ rtl/core/binary_max_heap_queue_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the priority queue
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BINARY_MAX_HEAP_QUEUE_DEFINES_SVH
`define BINARY_MAX_HEAP_QUEUE_DEFINES_SVH

// Same-cycle implication
`define BMHQ_ASSERT_IMM(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define BMHQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/bmhq_pkg.sv @@
// ----------------------------------------------------------------------------
// Priority queue package
// Opcodes, status codes and the command broadcast to every sorting cell.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  localparam int VAL_W = 32;

  // Input opcodes
  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_INSERT = 2'd0;
  localparam opcode_t OP_POP    = 2'd1;
  localparam opcode_t OP_REMOVE = 2'd2;

  // Result status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_FULL     = 2'd1;
  localparam status_t ST_EMPTY    = 2'd2;
  localparam status_t ST_NOTFOUND = 2'd3;

  // Cell operations
  typedef logic [2:0] cell_op_t;
  localparam cell_op_t CELL_HOLD   = 3'd0;
  localparam cell_op_t CELL_INSERT = 3'd1;
  localparam cell_op_t CELL_POP    = 3'd2;
  localparam cell_op_t CELL_REMOVE = 3'd3;
  localparam cell_op_t CELL_MARK   = 3'd4;
  localparam cell_op_t CELL_SCAN   = 3'd5;

  typedef struct packed {
    cell_op_t                 op;
    logic signed [VAL_W-1:0]  value;
  } cell_cmd_t;

endpackage

@@ rtl/core/bmhq_cell.sv @@
// ----------------------------------------------------------------------------
// Sorting cell
// Holds one entry of the descending sorted row and its match flag. Inserts,
// pops and removals shift entries by one place between neighbors.
// ----------------------------------------------------------------------------
module bmhq_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  logic                              clk,
  input  bmhq_pkg::cell_cmd_t               cmd,
  input  logic [CNT_W-1:0]                  count,
  input  logic signed [bmhq_pkg::VAL_W-1:0] left_data,
  input  logic                              left_keep,
  input  logic signed [bmhq_pkg::VAL_W-1:0] right_data,
  input  logic                              right_hit,
  output logic signed [bmhq_pkg::VAL_W-1:0] data,
  output logic                              keep,
  output logic                              hit
);
  import bmhq_pkg::*;

  logic signed [VAL_W-1:0] data_r, data_nxt;
  logic                    hit_r, hit_nxt;
  logic                    live;

  assign live = CNT_W'(IDX) < count;
  // Keep place on insert when this live entry ranks at or above the new value
  assign keep = live && (data_r >= cmd.value);

  // Select next entry and match flag
  always_comb begin
    data_nxt = data_r;
    hit_nxt  = hit_r;
    unique case (cmd.op)
      CELL_HOLD: begin
      end
      CELL_INSERT: begin
        if (!keep) begin
          data_nxt = left_keep ? cmd.value : left_data;
        end
      end
      CELL_POP: begin
        data_nxt = right_data;
      end
      CELL_REMOVE: begin
        if (data_r <= cmd.value) begin
          data_nxt = right_data;
        end
      end
      CELL_MARK: begin
        hit_nxt = live && (data_r == cmd.value);
      end
      CELL_SCAN: begin
        hit_nxt = right_hit;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    hit_r  <= hit_nxt;
  end

  assign data = data_r;
  assign hit  = hit_r;

endmodule

@@ rtl/core/binary_max_heap_queue.sv @@
// ----------------------------------------------------------------------------
// Max-priority queue
// Signed 32-bit values held in a row of sorting cells, largest in cell 0.
// Insert, pop of the maximum and removal of one copy of a value.
//
//   channel  dir  tdata                              tuser
//   in_      in   [31:0] value                       [1:0] opcode
//   out_     out  [31:0] top_value [38:32] count     [0] top_valid [2:1] status
//
// Insert, pop and the unused opcode run from accept to result in steps:
// accept, a step in which every cell shifts in parallel, load of the
// output register. Removal first marks the cells that hold the value; the
// match flags then walk through the cell row one cell a cycle toward cell
// 0, then the scan closes and a last step applies the shift.
// One item is in flight at a time; a result waiting in the output register
// holds the next result back. Reset empties the queue at once.
// ----------------------------------------------------------------------------
`include "binary_max_heap_queue_defines.svh"

module binary_max_heap_queue #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] top_value, [38:32] entry_count
  output logic [2:0]  out_tuser   // [0] top_valid, [2:1] status
);
  import bmhq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_APPLY = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]              state_r, state_nxt;
  opcode_t                 op_r, op_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        scan_cnt_r, scan_cnt_nxt;
  logic                    found_r, found_nxt;
  status_t                 status_r, status_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [39:0]             out_data_r, out_data_nxt;
  logic [2:0]              out_user_r, out_user_nxt;

  cell_cmd_t               cmd;
  logic signed [VAL_W-1:0] cell_data [CAPACITY];
  logic                    cell_keep [CAPACITY];
  logic                    cell_hit  [CAPACITY];

  logic [CNT_W+6:0]        count_ext;
  logic signed [VAL_W-1:0] top_val;
  logic                    in_beat;
  logic                    emit_ok;

  assign in_tready = (state_r == S_IDLE);
  assign in_beat   = in_tvalid && in_tready;
  assign emit_ok   = !out_valid_r || out_tready;
  assign count_ext = {7'd0, count_r};
  assign top_val   = (count_r != '0) ? cell_data[0] : '0;

  // Sequence one item through the cell row
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    val_nxt       = val_r;
    count_nxt     = count_r;
    scan_cnt_nxt  = scan_cnt_r;
    found_nxt     = found_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    cmd.op        = CELL_HOLD;
    cmd.value     = val_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          op_nxt    = in_tuser;
          val_nxt   = in_tdata;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        status_nxt = ST_OK;
        state_nxt  = S_EMIT;
        unique case (op_r)
          OP_INSERT: begin
            if (count_r < CNT_W'(CAPACITY)) begin
              cmd.op    = CELL_INSERT;
              count_nxt = count_r + 1'b1;
            end else begin
              status_nxt = ST_FULL;
            end
          end
          OP_POP: begin
            if (count_r != '0) begin
              cmd.op    = CELL_POP;
              count_nxt = count_r - 1'b1;
            end else begin
              status_nxt = ST_EMPTY;
            end
          end
          OP_REMOVE: begin
            cmd.op       = CELL_MARK;
            scan_cnt_nxt = count_r;
            found_nxt    = 1'b0;
            state_nxt    = S_SCAN;
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        if (scan_cnt_r == '0) begin
          state_nxt = S_APPLY;
        end else begin
          cmd.op       = CELL_SCAN;
          found_nxt    = found_r | cell_hit[0];
          scan_cnt_nxt = scan_cnt_r - 1'b1;
        end
      end
      S_APPLY: begin
        if (found_r) begin
          cmd.op     = CELL_REMOVE;
          count_nxt  = count_r - 1'b1;
          status_nxt = ST_OK;
        end else begin
          status_nxt = ST_NOTFOUND;
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, count_ext[6:0], top_val};
          out_user_nxt  = {status_r, (count_r != '0)};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Build the cell row and wire neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_data;
    logic                    left_keep;
    logic signed [VAL_W-1:0] right_data;
    logic                    right_hit;

    if (i == 0) begin : g_first
      assign left_data = '0;
      assign left_keep = 1'b1;
    end else begin : g_mid
      assign left_data = cell_data[i-1];
      assign left_keep = cell_keep[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_data = cell_data[i];
      assign right_hit  = 1'b0;
    end else begin : g_inner
      assign right_data = cell_data[i+1];
      assign right_hit  = cell_hit[i+1];
    end

    bmhq_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .count      (count_r),
      .left_data  (left_data),
      .left_keep  (left_keep),
      .right_data (right_data),
      .right_hit  (right_hit),
      .data       (cell_data[i]),
      .keep       (cell_keep[i]),
      .hit        (cell_hit[i])
    );
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Item and result registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    val_r      <= val_nxt;
    scan_cnt_r <= scan_cnt_nxt;
    found_r    <= found_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `BMHQ_ASSERT_IMM(a_count_bound, 1'b1, count_r <= CNT_W'(CAPACITY), "count above capacity")
  `BMHQ_ASSERT_NXT(a_insert_grows, (state_r == S_EXEC) && (op_r == OP_INSERT) && (count_r < CNT_W'(CAPACITY)), count_r == $past(count_r) + 1'b1, "insert did not grow count")
  `BMHQ_ASSERT_NXT(a_remove_shrinks, (state_r == S_APPLY) && found_r, count_r == $past(count_r) - 1'b1, "removal did not shrink count")
  `BMHQ_ASSERT_NXT(a_scan_exit, state_r == S_SCAN, (state_r == S_SCAN) || (state_r == S_APPLY), "scan left to wrong state")
  `BMHQ_ASSERT_NXT(a_one_item, in_tvalid && in_tready, !in_tready, "second item taken while busy")

endmodule

@@ test/bmhq_checker.sv @@
// ----------------------------------------------------------------------------
// Priority queue result checker
// Watches both streams of the max-priority queue. On every input beat it
// applies the command to its own heap and queues the report that the block
// must return. Each result beat is compared field by field with the oldest
// queued report.
// ----------------------------------------------------------------------------
module bmhq_checker #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // [31:0] top_value, [38:32] entry_count
  input  logic [2:0]  out_tuser,  // [0] top_valid, [2:1] status
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import bmhq_pkg::*;

  typedef struct packed {
    logic signed [VAL_W-1:0] top_value;
    logic                    top_valid;
    logic [6:0]              count;
    status_t                 status;
  } queue_report_t;

  logic signed [VAL_W-1:0] heap_mem [CAPACITY];
  int                      heap_size = 0;
  queue_report_t           report_q [$];
  queue_report_t           want;
  queue_report_t           got;
  int                      fail_count = 0;
  int                      waiting = 0;

  assign errors  = fail_count;
  assign pending = waiting;

  // Print one mismatch line and count it
  task automatic report_mismatch(input string what);
    $display("%0t ns  mismatch: %s", $time, what);
    fail_count++;
  endtask

  function automatic void swap_slots(input int a, input int b);
    logic signed [VAL_W-1:0] t;
    t           = heap_mem[a];
    heap_mem[a] = heap_mem[b];
    heap_mem[b] = t;
  endfunction

  // Move an entry toward the root; to_root ignores the ordering test
  function automatic void lift(input int idx, input bit to_root);
    int parent;
    bit stop;
    stop = 1'b0;
    while (!stop && idx > 0 && idx < CAPACITY) begin
      parent = (idx - 1) / 2;
      if (!to_root && heap_mem[idx] < heap_mem[parent]) begin
        stop = 1'b1;
      end else begin
        swap_slots(idx, parent);
        idx = parent;
      end
    end
  endfunction

  // Restore order from the root down; equal larger children go left
  function automatic void sink_root();
    int idx, l, r, nxt;
    logic signed [VAL_W-1:0] pv, lv, rv;
    bit has_r, stop;
    idx  = 0;
    stop = 1'b0;
    while (!stop && 2 * idx + 1 < heap_size) begin
      l     = 2 * idx + 1;
      r     = l + 1;
      pv    = heap_mem[idx];
      lv    = heap_mem[l];
      has_r = r < heap_size;
      rv    = has_r ? heap_mem[r] : lv;
      if (lv >= rv && lv > pv) begin
        nxt = l;
      end else if (has_r && rv > lv && rv > pv) begin
        nxt = r;
      end else begin
        stop = 1'b1;
      end
      if (!stop) begin
        swap_slots(idx, nxt);
        idx = nxt;
      end
    end
  endfunction

  function automatic void take_root();
    heap_size--;
    heap_mem[0] = heap_mem[heap_size];
    sink_root();
  endfunction

  // Apply one command to the heap and build the report it produces
  function automatic queue_report_t run_command(input opcode_t op,
                                                input logic signed [VAL_W-1:0] v);
    queue_report_t rep;
    bit hit;
    rep.status = ST_OK;
    case (op)
      OP_INSERT: begin
        if (heap_size >= CAPACITY) begin
          rep.status = ST_FULL;
        end else begin
          heap_mem[heap_size] = v;
          heap_size++;
          lift(heap_size - 1, 1'b0);
        end
      end
      OP_POP: begin
        if (heap_size == 0) rep.status = ST_EMPTY;
        else take_root();
      end
      OP_REMOVE: begin
        // first match in store order is raised to the root and popped
        rep.status = ST_NOTFOUND;
        hit = 1'b0;
        for (int i = 0; i < heap_size && !hit; i++) begin
          if (heap_mem[i] == v) begin
            hit = 1'b1;
            lift(i, 1'b1);
            take_root();
            rep.status = ST_OK;
          end
        end
      end
      default: ;
    endcase
    rep.top_valid = heap_size > 0;
    rep.top_value = (heap_size > 0) ? heap_mem[0] : '0;
    rep.count     = 7'(heap_size);
    return rep;
  endfunction

  // Check result beats first, then predict from the input beat of this edge
  always @(posedge clk) begin
    if (!rst_n) begin
      report_q.delete();
      heap_size = 0;
      waiting <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.top_value = out_tdata[31:0];
        got.count     = out_tdata[38:32];
        got.top_valid = out_tuser[0];
        got.status    = out_tuser[2:1];
        if (report_q.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = report_q.pop_front();
          if (got.top_value !== want.top_value)
            report_mismatch($sformatf("top_value got %0d want %0d",
                                      got.top_value, want.top_value));
          if (got.top_valid !== want.top_valid)
            report_mismatch($sformatf("top_valid got %b want %b",
                                      got.top_valid, want.top_valid));
          if (got.count !== want.count)
            report_mismatch($sformatf("entry_count got %0d want %0d",
                                      got.count, want.count));
          if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      got.status, want.status));
        end
      end
      if (in_tvalid && in_tready)
        report_q.insert(report_q.size(), run_command(in_tuser, in_tdata));
      waiting <= report_q.size();
    end
  end

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// Priority queue testbench
// Drives directed commands (empty pops and removes, extremes, duplicates,
// the unused opcode) and then bursts of fill, drain and mixed traffic with
// random gaps and result back-pressure. The checker predicts every report.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bmhq_pkg::*;

  typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIX} burst_mode_t;

  localparam int      CAPACITY    = 64;
  localparam int      N_RANDOM    = 1350;
  localparam int      QUIET_TAIL  = 150;
  localparam int      HOLD_CYCLES = 400;
  localparam int      CYCLE_LIMIT = 1000000;
  localparam int      POOL_N      = 16;
  localparam int      N_DIRECTED  = 23;
  localparam opcode_t OP_IDLE     = 2'd3;
  localparam logic [31:0] V_MIN   = 32'h8000_0000;
  localparam logic [31:0] V_MAX   = 32'h7fff_ffff;
  localparam logic [31:0] V_NEG1  = 32'hffff_ffff;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [2:0]  out_tuser;

  int          errors;
  int          pending;
  int          cycle_count = 0;
  bit          idle_on = 1'b1;
  bit          long_hold_req = 1'b0;
  logic [31:0] pool [POOL_N];
  logic [31:0] extreme_vals [4] = '{V_MIN, V_MAX, 32'h0, V_NEG1};

  always #10 clk = ~clk;

  binary_max_heap_queue #(.CAPACITY(CAPACITY)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  bmhq_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .errors    (errors),
    .pending   (pending)
  );

  // Offer one beat and hold it until accepted
  task automatic send_item(input opcode_t op, input logic [31:0] val);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= val;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drop valid for a random burst now and then
  task automatic sender_gap();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every report has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  // Pool values half the time so that removes hit and duplicates pile up
  function automatic logic [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return pool[$urandom_range(0, POOL_N - 1)];
    if (r < 65) return 32'($urandom_range(0, 16)) - 32'd8;
    if (r < 72) return extreme_vals[$urandom_range(0, 3)];
    return $urandom;
  endfunction

  function automatic opcode_t pick_op(input burst_mode_t m);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (m)
      MODE_FILL:
        return (r < 82) ? OP_INSERT : (r < 90) ? OP_POP : (r < 97) ? OP_REMOVE : OP_IDLE;
      MODE_DRAIN:
        return (r < 10) ? OP_INSERT : (r < 55) ? OP_POP : (r < 95) ? OP_REMOVE : OP_IDLE;
      default:
        return (r < 40) ? OP_INSERT : (r < 65) ? OP_POP : (r < 93) ? OP_REMOVE : OP_IDLE;
    endcase
  endfunction

  // Result side: random stalls, one long hold-off on request
  initial begin : result_sink
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_tready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Give up on a hung run
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: errors");
    $finish;
  end

  initial begin : stimulus
    // empty-heap cases, extremes, absent and present removes, equal children
    opcode_t     d_op [N_DIRECTED] = '{
      OP_POP, OP_REMOVE, OP_IDLE, OP_INSERT, OP_INSERT, OP_INSERT, OP_INSERT,
      OP_REMOVE, OP_REMOVE, OP_IDLE, OP_INSERT, OP_INSERT, OP_INSERT, OP_INSERT,
      OP_POP, OP_POP, OP_POP, OP_REMOVE, OP_POP, OP_POP, OP_POP, OP_POP, OP_POP};
    logic [31:0] d_val [N_DIRECTED] = '{
      32'd3, 32'd7, 32'd0, V_MIN, V_MAX, 32'd0, V_NEG1,
      32'd12, V_NEG1, 32'h5555_5555, 32'd9, 32'd5, 32'd5, 32'd1,
      32'hAAAA_AAAA, 32'd0, 32'd0, V_MIN, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
    int          n_rand;
    int          round;
    int          len;
    burst_mode_t mode;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_item(d_op[i], d_val[i]);
      sender_gap();
    end

    for (int i = 0; i < POOL_N; i++)
      pool[i] = (i < 6) ? 32'($urandom_range(0, 16)) - 32'd8 : $urandom;

    // bursts of traffic, starting with a fill so the heap runs full early
    n_rand = 0;
    round  = 0;
    while (n_rand < N_RANDOM) begin
      if (round == 0) mode = MODE_FILL;
      else mode = burst_mode_t'($urandom_range(0, 2));
      len = (mode == MODE_FILL) ? 110 : (mode == MODE_DRAIN) ? 100 : 60;
      if (round == 4) long_hold_req = 1'b1;
      if (round == 7) drain_results();
      pool[$urandom_range(0, POOL_N - 1)] = $urandom;
      pool[$urandom_range(0, 5)] = 32'($urandom_range(0, 16)) - 32'd8;
      for (int k = 0; k < len && n_rand < N_RANDOM; k++) begin
        if (n_rand >= N_RANDOM - QUIET_TAIL) idle_on = 1'b0;
        send_item(pick_op(mode), ($urandom_range(0, 4) == 0) ? $urandom : pick_value());
        n_rand++;
        sender_gap();
      end
      round++;
    end

    drain_results();
    repeat (CAPACITY + 8) @(posedge clk);
    if (errors == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
